// ===== sv/krm_pkg.sv =====
// ----------------------------------------------------------------------------
// krm_pkg
// Types, codes and constants shared by the keypress rate meter files.
// ----------------------------------------------------------------------------
package krm_pkg;

  localparam int HISTORY_DEPTH_DEF     = 64;
  localparam int ROW_SLOTS_DEF         = 13;
  localparam int LEFT_KEYS_PER_ROW_DEF = 6;

  localparam int POS_LIMIT = 64;
  localparam int POS_W     = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OFFSET     = 3'd5;

  localparam logic [15:0] WINDOW_MS_RST      = 16'd5000;
  localparam logic [7:0]  SLOW_THRESHOLD_RST = 8'd5;
  localparam logic [7:0]  MID_THRESHOLD_RST  = 8'd30;
  localparam logic [7:0]  FAST_THRESHOLD_RST = 8'd70;
  localparam logic [5:0]  MOVE_STEP_RST      = 6'd3;
  localparam logic [5:0]  MAX_OFFSET_RST     = 6'd14;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] LVL_IDLE = 2'd0;
  localparam logic [1:0] LVL_SLOW = 2'd1;
  localparam logic [1:0] LVL_MID  = 2'd2;
  localparam logic [1:0] LVL_FAST = 2'd3;

  // rate = (count*12+2)/5, division by 5 as multiply by ceil(2^14/5)
  localparam int          RATE_X_W     = 12;
  localparam logic [11:0] RATE_MUL     = 12'd12;
  localparam logic [11:0] RATE_ADD     = 12'd2;
  localparam int          RATE_P_W     = 24;
  localparam int          RATE_SHIFT   = 14;
  localparam logic [23:0] RATE_RECIP   = 24'd3277;
  localparam int          RATE_Q_W     = 10;
  localparam logic [9:0]  RATE_SAT     = 10'd255;

  // target = rate/5 as multiply by ceil(2^10/5)
  localparam int          TGT_P_W      = 18;
  localparam int          TGT_SHIFT    = 10;
  localparam logic [17:0] TGT_RECIP    = 18'd205;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  key_position;
    logic        key_pressed;
    logic [31:0] time_now;
  } in_item_t;

  typedef struct packed {
    logic [7:0] left_rate;
    logic [7:0] right_rate;
    logic [1:0] left_level;
    logic [1:0] right_level;
    logic [5:0] left_offset;
    logic [5:0] right_offset;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_START,
    ST_WALK,
    ST_RATE,
    ST_SLEW,
    ST_FINISH
  } krm_state_t;

  typedef struct packed {
    logic capture;
    logic write_press;
    logic walk_start;
    logic walk_step;
    logic calc_rate;
    logic calc_slew;
    logic out_load;
    logic side;
  } krm_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic press_ok;
    logic walk_done;
    logic out_free;
  } krm_status_t;

endpackage

// ===== sv/krm_if.sv =====
// ----------------------------------------------------------------------------
// krm_if
// Valid/ready channels of the keypress rate meter: input items and results.
// ----------------------------------------------------------------------------
interface krm_in_if;
  logic              valid;
  logic              ready;
  krm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface krm_out_if;
  logic               valid;
  logic               ready;
  krm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/krm_ram.sv =====
// ----------------------------------------------------------------------------
// krm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module krm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/krm_ctrl.sv =====
// ----------------------------------------------------------------------------
// krm_ctrl
// Sequencer: accepts items, runs the press write or the two-side tick walk.
// ----------------------------------------------------------------------------
module krm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  krm_pkg::krm_status_t status,
  output krm_pkg::krm_cmd_t    cmd
);

  import krm_pkg::*;

  krm_state_t state, state_next;
  logic       side, side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  always_comb begin
    state_next  = state;
    side_next   = side;
    item_ready  = 1'b0;
    cmd         = '0;
    cmd.side    = side;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.is_tick) begin
          side_next  = 1'b0;
          state_next = ST_START;
        end else if (status.press_ok) begin
          cmd.write_press = 1'b1;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_START: begin
        cmd.walk_start = 1'b1;
        state_next     = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_next = ST_RATE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_RATE: begin
        cmd.calc_rate = 1'b1;
        state_next    = ST_SLEW;
      end
      ST_SLEW: begin
        cmd.calc_slew = 1'b1;
        if (!side) begin
          side_next  = 1'b1;
          state_next = ST_START;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/krm_datapath.sv =====
// ----------------------------------------------------------------------------
// krm_datapath
// Registers, timestamp RAM, ring pointers, walk counter, rate and slew units.
// ----------------------------------------------------------------------------
module krm_datapath #(
  parameter int HISTORY_DEPTH     = krm_pkg::HISTORY_DEPTH_DEF,
  parameter int ROW_SLOTS         = krm_pkg::ROW_SLOTS_DEF,
  parameter int LEFT_KEYS_PER_ROW = krm_pkg::LEFT_KEYS_PER_ROW_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [krm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [krm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  krm_pkg::in_item_t                 item_data,
  input  krm_pkg::krm_cmd_t                 cmd,
  output krm_pkg::krm_status_t              status,
  krm_out_if.source                         result
);

  import krm_pkg::*;

  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HISTORY_DEPTH);

  logic [15:0] window_ms;
  logic [7:0]  slow_threshold;
  logic [7:0]  mid_threshold;
  logic [7:0]  fast_threshold;
  logic [5:0]  move_step;
  logic [5:0]  max_offset;

  in_item_t item_r;

  logic [POS_LIMIT-1:0] left_map;
  logic                 press_side;

  logic [IDX_W-1:0] heads [2];
  logic [CNT_W-1:0] fills [2];
  logic [IDX_W-1:0] ptr;
  logic [CNT_W-1:0] issued;
  logic [CNT_W-1:0] count;
  logic             pend;
  logic             stop;

  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       rd_data;
  logic [31:0]       age;
  logic              hit;
  logic              fail;
  logic              issue;

  logic [7:0] rate_r   [2];
  logic [1:0] level_r  [2];
  logic [5:0] offset   [2];

  logic [RATE_X_W-1:0] rate_x;
  logic [RATE_P_W-1:0] rate_prod;
  logic [RATE_Q_W-1:0] rate_q;
  logic [7:0]          rate_new;

  logic [7:0]         cur_rate;
  logic [TGT_P_W-1:0] tgt_prod;
  logic [7:0]         tgt_raw;
  logic [5:0]         tgt;
  logic [5:0]         cur;
  logic [6:0]         up;
  logic [5:0]         gap;
  logic [5:0]         offset_new;
  logic [1:0]         level_new;

  for (genvar p = 0; p < POS_LIMIT; p++) begin : g_side_map
    assign left_map[p] = ((p % ROW_SLOTS) < LEFT_KEYS_PER_ROW);
  end

  assign press_side = ~left_map[item_r.key_position[POS_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms      <= WINDOW_MS_RST;
      slow_threshold <= SLOW_THRESHOLD_RST;
      mid_threshold  <= MID_THRESHOLD_RST;
      fast_threshold <= FAST_THRESHOLD_RST;
      move_step      <= MOVE_STEP_RST;
      max_offset     <= MAX_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_MS:      window_ms      <= cfg_data;
        CFG_SLOW_THRESHOLD: slow_threshold <= cfg_data[7:0];
        CFG_MID_THRESHOLD:  mid_threshold  <= cfg_data[7:0];
        CFG_FAST_THRESHOLD: fast_threshold <= cfg_data[7:0];
        CFG_MOVE_STEP:      move_step      <= cfg_data[5:0];
        CFG_MAX_OFFSET:     max_offset     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= item_data;
    end
  end

  assign waddr = {press_side, heads[press_side]};
  assign raddr = {cmd.side, ptr};

  krm_ram #(
    .WIDTH (32),
    .DEPTH (2 * (2 ** IDX_W))
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write_press),
    .waddr (waddr),
    .wdata (item_r.time_now),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign age   = item_r.time_now - rd_data;
  assign hit   = pend && (age <= {16'd0, window_ms});
  assign fail  = pend && !hit;
  assign issue = cmd.walk_step && !fail && !stop && (issued != fills[cmd.side]);

  always_ff @(posedge clk) begin
    if (rst) begin
      heads[0] <= '0;
      heads[1] <= '0;
      fills[0] <= '0;
      fills[1] <= '0;
    end else if (cmd.write_press) begin
      heads[press_side] <= (heads[press_side] == IDX_LAST) ? '0 : heads[press_side] + 1'b1;
      if (fills[press_side] != CNT_FULL) begin
        fills[press_side] <= fills[press_side] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      stop <= 1'b0;
    end else if (cmd.walk_start) begin
      pend <= 1'b0;
      stop <= 1'b0;
    end else if (cmd.walk_step) begin
      pend <= issue;
      if (fail) begin
        stop <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      ptr    <= (heads[cmd.side] == '0) ? IDX_LAST : heads[cmd.side] - 1'b1;
      issued <= '0;
      count  <= '0;
    end else if (cmd.walk_step) begin
      if (hit) begin
        count <= count + 1'b1;
      end
      if (issue) begin
        ptr    <= (ptr == '0) ? IDX_LAST : ptr - 1'b1;
        issued <= issued + 1'b1;
      end
    end
  end

  always_comb begin
    rate_x    = RATE_X_W'(count) * RATE_MUL + RATE_ADD;
    rate_prod = RATE_P_W'(rate_x) * RATE_RECIP;
    rate_q    = rate_prod[RATE_P_W-1:RATE_SHIFT];
    rate_new  = (rate_q > RATE_SAT) ? 8'd255 : rate_q[7:0];
  end

  always_comb begin
    cur_rate = rate_r[cmd.side];
    cur      = offset[cmd.side];
    tgt_prod = TGT_P_W'(cur_rate) * TGT_RECIP;
    tgt_raw  = tgt_prod[TGT_P_W-1:TGT_SHIFT];
    tgt      = (tgt_raw > {2'b00, max_offset}) ? max_offset : tgt_raw[5:0];
    up       = {1'b0, cur} + {1'b0, move_step};
    gap      = cur - tgt;
    if (cur < tgt) begin
      offset_new = (up > {1'b0, tgt}) ? tgt : up[5:0];
    end else if (cur > tgt) begin
      offset_new = (gap <= move_step) ? tgt : cur - move_step;
    end else begin
      offset_new = cur;
    end
    if (cur_rate >= fast_threshold) begin
      level_new = LVL_FAST;
    end else if (cur_rate >= mid_threshold) begin
      level_new = LVL_MID;
    end else if (cur_rate >= slow_threshold) begin
      level_new = LVL_SLOW;
    end else begin
      level_new = LVL_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_rate) begin
      rate_r[cmd.side] <= rate_new;
    end
    if (cmd.calc_slew) begin
      level_r[cmd.side] <= level_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset[0] <= '0;
      offset[1] <= '0;
    end else if (cmd.calc_slew) begin
      offset[cmd.side] <= offset_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.data.left_rate    <= rate_r[0];
      result.data.right_rate   <= rate_r[1];
      result.data.left_level   <= level_r[0];
      result.data.right_level  <= level_r[1];
      result.data.left_offset  <= offset[0];
      result.data.right_offset <= offset[1];
    end
  end

  assign status.is_tick   = (item_r.cmd == CMD_TICK);
  assign status.press_ok  = (item_r.cmd == CMD_KEY) && item_r.key_pressed &&
                            (item_r.key_position < 8'(POS_LIMIT));
  assign status.walk_done = !pend && (stop || (issued == fills[cmd.side]));
  assign status.out_free  = !result.valid || result.ready;

endmodule

// ===== sv/keypress_rate_meter.sv =====
// ----------------------------------------------------------------------------
// keypress_rate_meter
// Two-sided keystroke rate meter with level classification and slewed offset.
// ----------------------------------------------------------------------------
// A key event is captured, then dispatched; presses below position 64 store
// their time in the ring of their side. A tick walks the stored presses of
// each side (at most HISTORY_DEPTH each, ending early at the first press
// older than the window): the walk reads the shared timestamp RAM one entry
// per cycle, left side first. The tick then waits for the output register
// to free. A finished result waits in the output register while the next
// item is taken.
// ----------------------------------------------------------------------------
module keypress_rate_meter #(
  parameter int HISTORY_DEPTH     = krm_pkg::HISTORY_DEPTH_DEF,
  parameter int ROW_SLOTS         = krm_pkg::ROW_SLOTS_DEF,
  parameter int LEFT_KEYS_PER_ROW = krm_pkg::LEFT_KEYS_PER_ROW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [krm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [krm_pkg::CFG_DATA_W-1:0] cfg_data,
  krm_in_if.sink                         item,
  krm_out_if.source                      result
);

  import krm_pkg::*;

  krm_cmd_t    cmd;
  krm_status_t status;

  krm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  krm_datapath #(
    .HISTORY_DEPTH     (HISTORY_DEPTH),
    .ROW_SLOTS         (ROW_SLOTS),
    .LEFT_KEYS_PER_ROW (LEFT_KEYS_PER_ROW)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_data (item.data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
